// ===== rtl/wmcs_pkg.sv =====
package wmcs_pkg;

    localparam int MAX_NEURONS_DEF = 4096;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int DATA_W      = 32;
    localparam int SUM_W       = 64;
    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 64;
    localparam int CFG_ADDR_W  = 3;

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_MODE       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LEAK       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_REST       = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_EXC_REV    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_INH_REV    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_FIRST_STEP = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_LAST_STEP  = 3'd6;

    // current kinds
    localparam logic [1:0] MODE_TOTAL = 2'd0;
    localparam logic [1:0] MODE_LEAK  = 2'd1;
    localparam logic [1:0] MODE_EXC   = 2'd2;
    localparam logic [1:0] MODE_INH   = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] voltage;
        logic signed [DATA_W-1:0] exc_conductance;
        logic signed [DATA_W-1:0] inh_conductance;
        logic signed [DATA_W-1:0] weight;
        logic                     take;
        logic                     last_in_step;
    } item_t;

    typedef struct packed {
        logic [1:0]               mode;
        logic [DATA_W-2:0]        leak_conductance;
        logic signed [DATA_W-1:0] rest_potential;
        logic signed [DATA_W-1:0] exc_reversal;
        logic signed [DATA_W-1:0] inh_reversal;
        logic [DATA_W-1:0]        first_step;
        logic [DATA_W-1:0]        last_step;
    } cfg_t;

endpackage

// ===== rtl/weighted_membrane_current_sum.sv =====
// Weighted membrane current sum: one mean field value per simulated time step in the window.
//
// Slave channel (s_*): one neuron sample per beat. s_tlast marks the last
// sample of a time step, s_tuser says the neuron is selected. Master channel
// (m_*): one beat per finished step whose index lies in [first_step,
// last_step); m_tuser flags a step with no selected neuron (value 0).
// Configuration: cfg_we/cfg_addr/cfg_data, write while the block is idle.
//
// Throughput: the front accepts a sample every cycle while the 4-entry queue
// has room. The back unit pops one unselected sample per cycle while it is
// idle, and takes a selected one through difference, three parallel products,
// sum and saturate, weight multiply and accumulate before it pops again.
// Closing a step passes through a check; a step inside the window then waits
// for the one-bit-per-cycle 64-bit divider when it holds a selected neuron and
// emits a beat. Reset clears the configuration, the state, the sum, the count,
// the step index and the output valid flag and drops any queued beats. A
// stalled result holds in the output register; the back unit then waits, the
// queue fills and s_tready drops.
module weighted_membrane_current_sum
    import wmcs_pkg::*;
#(
    parameter int MAX_NEURONS = MAX_NEURONS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // sample stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // voltage, exc_conductance, inh_conductance, weight
    input  logic                   s_tuser,   // selected
    input  logic                   s_tlast,   // last_in_step
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // field_value, step_index
    output logic                   m_tuser,   // empty_step
    // configuration writes
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [DATA_W-1:0]      cfg_data
);

    cfg_t              cfg_reg;
    logic              q_full;
    logic              push;
    item_t             push_item;
    logic              pop;
    item_t             head;
    logic              head_valid;
    logic [DATA_W-1:0] out_field;
    logic [DATA_W-1:0] out_step;

    // register file; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_MODE:       cfg_reg.mode             <= cfg_data[1:0];
                REG_LEAK:       cfg_reg.leak_conductance <= cfg_data[DATA_W-2:0];
                REG_REST:       cfg_reg.rest_potential   <= $signed(cfg_data);
                REG_EXC_REV:    cfg_reg.exc_reversal     <= $signed(cfg_data);
                REG_INH_REV:    cfg_reg.inh_reversal     <= $signed(cfg_data);
                REG_FIRST_STEP: cfg_reg.first_step       <= cfg_data;
                REG_LAST_STEP:  cfg_reg.last_step        <= cfg_data;
                default:        ;
            endcase
        end
    end

    // classify samples and enforce the per-step neuron limit
    wmcs_front #(
        .MAX_NEURONS (MAX_NEURONS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    // decouple intake from the multi-cycle arithmetic
    wmcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    // current, weighting, accumulation, per-step mean and output register
    wmcs_back #(
        .MAX_NEURONS (MAX_NEURONS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_field  (out_field),
        .out_step   (out_step),
        .out_empty  (m_tuser)
    );

    assign m_tdata = {out_step, out_field};

endmodule

// ===== rtl/wmcs_front.sv =====
module wmcs_front
    import wmcs_pkg::*;
#(
    parameter int MAX_NEURONS = MAX_NEURONS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    input  logic                  q_full,
    output logic                  push,
    output item_t                 push_item
);

    localparam int CNT_W = $clog2(MAX_NEURONS + 1);

    logic [CNT_W-1:0] sel_cnt_reg;
    logic [CNT_W-1:0] sel_cnt_next;
    logic             take;

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    // a selected sample past the per-step limit is dropped from the sum
    assign take = s_tuser && (sel_cnt_reg < CNT_W'(MAX_NEURONS));

    always_comb
    begin
        push_item.voltage         = $signed(s_tdata[31:0]);
        push_item.exc_conductance = $signed(s_tdata[63:32]);
        push_item.inh_conductance = $signed(s_tdata[95:64]);
        push_item.weight          = $signed(s_tdata[127:96]);
        push_item.take            = take;
        push_item.last_in_step    = s_tlast;
    end

    always_comb
    begin
        sel_cnt_next = sel_cnt_reg;
        if (push)
        begin
            if (s_tlast)
                sel_cnt_next = '0;
            else if (take)
                sel_cnt_next = sel_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_cnt_reg <= '0;
        else
            sel_cnt_reg <= sel_cnt_next;
    end

endmodule

// ===== rtl/wmcs_queue.sv =====
module wmcs_queue
    import wmcs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output item_t head,
    output logic  head_valid
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;

    assign full       = (fill_reg == CNT_W'(DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                fill_reg <= fill_reg + 1'b1;
            else if (pop && !push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

endmodule

// ===== rtl/wmcs_div.sv =====
module wmcs_div
    import wmcs_pkg::*;
#(
    parameter int DIVISOR_W = 13
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [SUM_W-1:0]     dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic                 done,
    output logic [SUM_W-1:0]     quotient
);

    localparam int ITER_W = $clog2(SUM_W);

    logic                 busy_reg;
    logic                 done_reg;
    logic [ITER_W-1:0]    iter_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [SUM_W-1:0]     quo_reg;
    logic [DIVISOR_W-1:0] dsr_reg;

    logic [DIVISOR_W:0]   rem_shift;
    logic                 fits;
    logic [DIVISOR_W:0]   rem_sub;

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[SUM_W-1]};
        fits      = (rem_shift >= {1'b0, dsr_reg});
        rem_sub   = fits ? (rem_shift - {1'b0, dsr_reg}) : rem_shift;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_sub[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg + 1'b1;
                if (iter_reg == ITER_W'(SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/wmcs_back.sv =====
module wmcs_back
    import wmcs_pkg::*;
#(
    parameter int MAX_NEURONS = MAX_NEURONS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  item_t             head,
    input  logic              head_valid,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_field,
    output logic [DATA_W-1:0] out_step,
    output logic              out_empty
);

    localparam int CNT_W = $clog2(MAX_NEURONS + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DIFF  = 4'd1;
    localparam logic [3:0] ST_MUL   = 4'd2;
    localparam logic [3:0] ST_SUM   = 4'd3;
    localparam logic [3:0] ST_WMUL  = 4'd4;
    localparam logic [3:0] ST_ACC   = 4'd5;
    localparam logic [3:0] ST_CHECK = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_EMIT  = 4'd8;

    function automatic logic signed [DATA_W-1:0] sat_to_32(input logic signed [SUM_W-1:0] x);
        if (x > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (x < -64'sd2147483648)
            return 32'sh80000000;
        else
            return x[DATA_W-1:0];
    endfunction

    logic [3:0]               state_reg;
    logic [3:0]               state_next;

    item_t                    item_reg;
    logic signed [DATA_W-1:0] d_leak_reg;
    logic signed [DATA_W-1:0] d_exc_reg;
    logic signed [DATA_W-1:0] d_inh_reg;
    logic signed [SUM_W-1:0]  p_leak_reg;
    logic signed [SUM_W-1:0]  p_exc_reg;
    logic signed [SUM_W-1:0]  p_inh_reg;
    logic signed [DATA_W-1:0] cur_reg;
    logic signed [SUM_W-1:0]  wprod_reg;
    logic                     neg_reg;
    logic [DATA_W-1:0]        res_field_reg;
    logic                     res_empty_reg;

    logic signed [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [DATA_W-1:0]        step_reg;

    logic                     out_valid_reg;
    logic [DATA_W-1:0]        out_field_reg;
    logic [DATA_W-1:0]        out_step_reg;
    logic                     out_empty_reg;

    logic signed [DATA_W:0]   dl;
    logic signed [DATA_W:0]   de;
    logic signed [DATA_W:0]   di;
    logic                     use_leak;
    logic                     use_exc;
    logic                     use_inh;
    logic signed [DATA_W-1:0] g_leak;
    logic signed [DATA_W-1:0] g_exc;
    logic signed [DATA_W-1:0] g_inh;
    logic signed [SUM_W-1:0]  term_sum;
    logic                     in_window;
    logic [SUM_W-1:0]         sum_mag;
    logic                     div_start;
    logic                     div_done;
    logic [SUM_W-1:0]         div_quo;
    logic [DATA_W-1:0]        mean;
    logic                     out_load;

    always_comb
    begin
        dl = $signed({item_reg.voltage[DATA_W-1], item_reg.voltage})
           - $signed({cfg.rest_potential[DATA_W-1], cfg.rest_potential});
        de = $signed({item_reg.voltage[DATA_W-1], item_reg.voltage})
           - $signed({cfg.exc_reversal[DATA_W-1], cfg.exc_reversal});
        di = $signed({item_reg.voltage[DATA_W-1], item_reg.voltage})
           - $signed({cfg.inh_reversal[DATA_W-1], cfg.inh_reversal});

        use_leak = cfg.mode inside {MODE_TOTAL, MODE_LEAK};
        use_exc  = cfg.mode inside {MODE_TOTAL, MODE_EXC};
        use_inh  = cfg.mode inside {MODE_TOTAL, MODE_INH};

        // a term the mode leaves out gets a zero conductance
        g_leak = use_leak ? $signed({1'b0, cfg.leak_conductance}) : '0;
        g_exc  = use_exc  ? item_reg.exc_conductance : '0;
        g_inh  = use_inh  ? item_reg.inh_conductance : '0;

        term_sum = (p_leak_reg >>> 16) + (p_exc_reg >>> 16) + (p_inh_reg >>> 16);

        in_window = (step_reg >= cfg.first_step) && (step_reg < cfg.last_step);
        sum_mag   = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;

        if (neg_reg)
            mean = (div_quo > 64'h0000_0000_8000_0000) ? 32'h8000_0000
                 : (~div_quo[DATA_W-1:0] + 1'b1);
        else
            mean = (div_quo > 64'h0000_0000_7fff_ffff) ? 32'h7fff_ffff
                 : div_quo[DATA_W-1:0];
    end

    assign pop       = (state_reg == ST_IDLE) && head_valid;
    assign div_start = (state_reg == ST_CHECK) && in_window && (cnt_reg != '0);
    assign out_load  = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    if (head.take)
                        state_next = ST_DIFF;
                    else if (head.last_in_step)
                        state_next = ST_CHECK;
                end
            end
            ST_DIFF:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_SUM;
            ST_SUM:   state_next = ST_WMUL;
            ST_WMUL:  state_next = ST_ACC;
            ST_ACC:   state_next = item_reg.last_in_step ? ST_CHECK : ST_IDLE;
            ST_CHECK:
            begin
                if (!in_window)
                    state_next = ST_IDLE;
                else if (cnt_reg == '0)
                    state_next = ST_EMIT;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:   state_next = div_done ? ST_EMIT : ST_DIV;
            ST_EMIT:  state_next = out_load ? ST_IDLE : ST_EMIT;
            default:  state_next = ST_IDLE;
        endcase
    end

    wmcs_div #(
        .DIVISOR_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (pop)
            item_reg <= head;
        if (state_reg == ST_DIFF)
        begin
            d_leak_reg <= sat_to_32(SUM_W'(dl));
            d_exc_reg  <= sat_to_32(SUM_W'(de));
            d_inh_reg  <= sat_to_32(SUM_W'(di));
        end
        if (state_reg == ST_MUL)
        begin
            p_leak_reg <= g_leak * d_leak_reg;
            p_exc_reg  <= g_exc * d_exc_reg;
            p_inh_reg  <= g_inh * d_inh_reg;
        end
        if (state_reg == ST_SUM)
            cur_reg <= sat_to_32(-term_sum);
        if (state_reg == ST_WMUL)
            wprod_reg <= cur_reg * item_reg.weight;
        if (state_reg == ST_CHECK)
        begin
            neg_reg       <= sum_reg[SUM_W-1];
            res_field_reg <= '0;
            res_empty_reg <= (cnt_reg == '0);
        end
        if ((state_reg == ST_DIV) && div_done)
            res_field_reg <= mean;
        if (out_load)
        begin
            out_field_reg <= res_field_reg;
            out_step_reg  <= step_reg;
            out_empty_reg <= res_empty_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_ACC)
            begin
                sum_reg <= sum_reg + (wprod_reg >>> 16);
                cnt_reg <= cnt_reg + 1'b1;
            end
            // close the step: clear the sum and count, advance the index
            if (((state_reg == ST_CHECK) && !in_window) || out_load)
            begin
                sum_reg  <= '0;
                cnt_reg  <= '0;
                step_reg <= step_reg + 1'b1;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_field = out_field_reg;
    assign out_step  = out_step_reg;
    assign out_empty = out_empty_reg;

endmodule

// ===== rtl/wmcs_checker.sv =====
module wmcs_checker
    import wmcs_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [IN_TDATA_W-1:0]  s_tdata,
    input logic                   s_tuser,
    input logic                   s_tlast,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tuser,
    input logic                   cfg_we,
    input logic [CFG_ADDR_W-1:0]  cfg_addr,
    input logic [DATA_W-1:0]      cfg_data
);

    // step ends accepted minus result beats sent; steps outside the window stay counted
    logic [DATA_W-1:0] pend_reg;
    logic              end_in;
    logic              res_out;

    assign end_in  = s_tvalid && s_tready && s_tlast;
    assign res_out = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else if (end_in && !res_out)
            pend_reg <= pend_reg + 1'b1;
        else if (res_out && !end_in)
            pend_reg <= pend_reg - 1'b1;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[DATA_W-1:0] == '0)
        else $error("empty step carries a nonzero value");

    a_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pend_reg != '0)
        else $error("result beat without a closed time step");

    logic unused_ok;
    assign unused_ok = ^{s_tdata, s_tuser, cfg_we, cfg_addr, cfg_data};

endmodule

bind weighted_membrane_current_sum wmcs_checker u_wmcs_checker (.*);
